// File: rtl/point_in_polygon_test_unit_assert.svh
`ifndef POINT_IN_POLYGON_TEST_UNIT_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define PIP_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("pip check failed");

// next-cycle implication under reset
`define PIP_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("pip check failed");

`endif

// File: rtl/pip_pkg.sv
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;

    localparam int ADDR_BITS  = $clog2(MAX_VERTICES);
    localparam int CNT_BITS   = $clog2(MAX_VERTICES + 1);
    localparam int TOTAL_BITS = 7;
    localparam int FIELD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic                 accept;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_idx;
        logic                 rd_first;
        logic                 rd_last;
    } pip_cmd_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic                query_done;
    } pip_status_t;

endpackage

// File: rtl/point_in_polygon_test_unit.sv
// Point-in-polygon unit with a stored vertex list. An item is taken when start is high
// and busy is low; its result shows for one cycle with done high and cannot be held off,
// so the receiver must take it then. Clear, append and unused-mode items give their result
// the cycle after they are taken and keep busy low, one item per cycle. A query over n
// stored vertices keeps busy high while its edges pass through and gives its result right after: the
// single read port of the vertex store delivers one vertex a cycle into a three-stage edge
// pipeline (classify, multiply, sign and accumulate). A query with no vertices keeps busy
// low and answers the cycle after it is taken, like a clear. The answer is 1 for inside or
// on the boundary; only listed edges are tested.
module point_in_polygon_test_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            mode,
    input  logic signed [pip_pkg::FIELD_BITS-1:0] coord_x,
    input  logic signed [pip_pkg::FIELD_BITS-1:0] coord_y,
    output logic                                  done,
    output logic                                  is_inside,
    output logic                                  is_closed,
    output logic [pip_pkg::TOTAL_BITS-1:0]        vertex_total,
    output logic                                  store_full
);

    pip_pkg::pip_cmd_t    cmd;
    pip_pkg::pip_status_t status;

    pip_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    pip_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .cmd          (cmd),
        .status       (status),
        .done         (done),
        .is_inside    (is_inside),
        .is_closed    (is_closed),
        .vertex_total (vertex_total),
        .store_full   (store_full)
    );

endmodule

// File: rtl/pip_ctrl.sv
module pip_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           mode,
    output logic                 busy,
    output pip_pkg::pip_cmd_t    cmd,
    input  pip_pkg::pip_status_t status
);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} state_t;

    state_t                        state_reg, state_next;
    logic [pip_pkg::ADDR_BITS-1:0] idx_reg, idx_next;
    logic                          accept;
    logic                          last_idx;

    assign accept   = start && (state_reg == ST_IDLE);
    assign last_idx = (pip_pkg::CNT_BITS'(idx_reg)
                       == (status.count - pip_pkg::CNT_BITS'(1)));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == pip_pkg::MODE_QUERY)
                    && (status.count != '0))
                begin
                    state_next = ST_ISSUE;
                    idx_next   = '0;
                end
            end
            ST_ISSUE:
            begin
                if (last_idx)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + pip_pkg::ADDR_BITS'(1);
                end
            end
            ST_WAIT:
            begin
                if (status.query_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cmd.accept   = accept;
    assign cmd.rd_en    = (state_reg == ST_ISSUE);
    assign cmd.rd_idx   = idx_reg;
    assign cmd.rd_first = (idx_reg == '0);
    assign cmd.rd_last  = last_idx;

endmodule

// File: rtl/pip_datapath.sv
module pip_datapath
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [1:0]                               mode,
    input  logic signed [pip_pkg::FIELD_BITS-1:0]    coord_x,
    input  logic signed [pip_pkg::FIELD_BITS-1:0]    coord_y,
    input  pip_pkg::pip_cmd_t                        cmd,
    output pip_pkg::pip_status_t                     status,
    output logic                                     done,
    output logic                                     is_inside,
    output logic                                     is_closed,
    output logic [pip_pkg::TOTAL_BITS-1:0]           vertex_total,
    output logic                                     store_full
);

    localparam int CB = pip_pkg::COORD_BITS;
    localparam int DB = pip_pkg::DIFF_BITS;
    localparam int PB = pip_pkg::PROD_BITS;

    logic signed [CB-1:0] mem_x [pip_pkg::MAX_VERTICES];
    logic signed [CB-1:0] mem_y [pip_pkg::MAX_VERTICES];

    logic signed [CB-1:0] in_x, in_y;
    logic [pip_pkg::CNT_BITS-1:0] count_reg;
    logic                 full;
    logic                 do_append;

    logic signed [CB-1:0] first_x_reg, first_y_reg, last_x_reg, last_y_reg;
    logic signed [CB-1:0] px_reg, py_reg, prev_x_reg, prev_y_reg;
    logic signed [CB-1:0] rd_x_reg, rd_y_reg;
    logic                 s0_valid_reg, s0_first_reg, s0_last_reg;

    logic                 sa_valid_reg, sa_last_reg, sa_early_reg, sa_zero_reg;
    logic signed [DB-1:0] sa_d0_reg, sa_d1_reg, sa_d2_reg, sa_d3_reg;
    logic                 sb_valid_reg, sb_last_reg, sb_early_reg, sb_zero_reg;
    logic signed [PB-1:0] sb_p1_reg, sb_p2_reg;

    logic                 neg_reg, zero_reg, neg_next, zero_next;
    logic                 done_reg, inside_reg, full_reg;

    logic signed [CB-1:0] lx, ly, hx, hy;
    logic                 hz, between, swap, hit, outr, early, early_zero;
    logic signed [PB:0]   cross_sum;

    assign in_x      = CB'(coord_x);
    assign in_y      = CB'(coord_y);
    assign full      = (count_reg == pip_pkg::CNT_BITS'(pip_pkg::MAX_VERTICES));
    assign do_append = cmd.accept && (mode == pip_pkg::MODE_APPEND) && !full;

    // vertex store
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            mem_x[count_reg[pip_pkg::ADDR_BITS-1:0]] <= in_x;
            mem_y[count_reg[pip_pkg::ADDR_BITS-1:0]] <= in_y;
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[cmd.rd_idx];
            rd_y_reg <= mem_y[cmd.rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.accept && (mode == pip_pkg::MODE_CLEAR))
        begin
            count_reg <= '0;
        end
        else if (do_append)
        begin
            count_reg <= count_reg + pip_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            if (count_reg == '0)
            begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
            end
            last_x_reg <= in_x;
            last_y_reg <= in_y;
        end
        if (cmd.accept)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (s0_valid_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
    end

    // edge classification: b is previous vertex, c the current one
    always_comb
    begin
        hz      = (py_reg == prev_y_reg) && (prev_y_reg == rd_y_reg);
        between = ((prev_x_reg <= px_reg) && (px_reg <= rd_x_reg))
                  || ((rd_x_reg <= px_reg) && (px_reg <= prev_x_reg));
        swap    = (prev_y_reg > rd_y_reg);
        lx      = swap ? rd_x_reg : prev_x_reg;
        ly      = swap ? rd_y_reg : prev_y_reg;
        hx      = swap ? prev_x_reg : rd_x_reg;
        hy      = swap ? prev_y_reg : rd_y_reg;
        hit     = (py_reg == ly) && (px_reg == lx);
        outr    = (py_reg <= ly) || (py_reg > hy);
        early   = hz || hit || outr;
        if (hz)
        begin
            early_zero = between;
        end
        else
        begin
            early_zero = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_first_reg <= 1'b0;
            s0_last_reg  <= 1'b0;
            sa_valid_reg <= 1'b0;
            sa_last_reg  <= 1'b0;
            sb_valid_reg <= 1'b0;
            sb_last_reg  <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= cmd.rd_en;
            s0_first_reg <= cmd.rd_en && cmd.rd_first;
            s0_last_reg  <= cmd.rd_en && cmd.rd_last;
            sa_valid_reg <= s0_valid_reg && !s0_first_reg;
            sa_last_reg  <= s0_last_reg;
            sb_valid_reg <= sa_valid_reg;
            sb_last_reg  <= sa_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_early_reg <= early;
        sa_zero_reg  <= early_zero;
        sa_d0_reg    <= DB'(lx) - DB'(px_reg);
        sa_d1_reg    <= DB'(hy) - DB'(py_reg);
        sa_d2_reg    <= DB'(ly) - DB'(py_reg);
        sa_d3_reg    <= DB'(hx) - DB'(px_reg);
        sb_early_reg <= sa_early_reg;
        sb_zero_reg  <= sa_zero_reg;
        sb_p1_reg    <= sa_d0_reg * sa_d1_reg;
        sb_p2_reg    <= sa_d2_reg * sa_d3_reg;
    end

    // running product kept as zero flag and sign
    always_comb
    begin
        cross_sum = (PB + 1)'(sb_p1_reg) - (PB + 1)'(sb_p2_reg);
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (sb_valid_reg)
        begin
            if (sb_early_reg)
            begin
                if (sb_zero_reg)
                begin
                    zero_next = 1'b1;
                end
            end
            else if (cross_sum == '0)
            begin
                zero_next = 1'b1;
            end
            else if (cross_sum > 0)
            begin
                neg_next = !neg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg    <= 1'b1;
            zero_reg   <= 1'b0;
            done_reg   <= 1'b0;
            inside_reg <= 1'b0;
            full_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                neg_reg  <= 1'b1;
                zero_reg <= 1'b0;
            end
            else
            begin
                neg_reg  <= neg_next;
                zero_reg <= zero_next;
            end
            done_reg   <= 1'b0;
            inside_reg <= 1'b0;
            full_reg   <= 1'b0;
            if (cmd.accept && ((mode != pip_pkg::MODE_QUERY) || (count_reg == '0)))
            begin
                done_reg <= 1'b1;
                full_reg <= (mode == pip_pkg::MODE_APPEND) && full;
            end
            else if (sb_last_reg)
            begin
                done_reg   <= 1'b1;
                inside_reg <= zero_next || !neg_next;
            end
        end
    end

    assign status.count      = count_reg;
    assign status.query_done = sb_last_reg;

    assign done         = done_reg;
    assign is_inside    = done_reg && inside_reg;
    assign store_full   = done_reg && full_reg;
    assign vertex_total = pip_pkg::TOTAL_BITS'(count_reg);
    assign is_closed    = (count_reg >= pip_pkg::CNT_BITS'(2))
                          && (first_x_reg == last_x_reg) && (first_y_reg == last_y_reg);

endmodule

// File: rtl/pip_checker.sv
`include "point_in_polygon_test_unit_assert.svh"

module pip_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic [1:0]                            mode,
    input logic                                  done,
    input logic                                  is_inside,
    input logic                                  is_closed,
    input logic [pip_pkg::TOTAL_BITS-1:0]        vertex_total,
    input logic                                  store_full
);

    logic clear_beat;
    logic flag_beat;
    logic at_limit;
    logic empty_result;
    logic has_edge;

    assign clear_beat   = start && !busy && (mode == pip_pkg::MODE_CLEAR);
    assign flag_beat    = is_inside || store_full;
    assign at_limit     = (vertex_total == pip_pkg::TOTAL_BITS'(pip_pkg::MAX_VERTICES));
    assign empty_result = done && !busy && (vertex_total == '0) && !is_closed && !is_inside;
    assign has_edge     = (vertex_total >= pip_pkg::TOTAL_BITS'(2));

    // no result while a query is walking its edges
    `PIP_ASSERT_NOW(a_busy_no_done, clk, rst_n, busy, !done)
    // flags only show with a result beat
    `PIP_ASSERT_NOW(a_flags_with_done, clk, rst_n, flag_beat, done)
    // a dropped append means the store is at its limit
    `PIP_ASSERT_NOW(a_full_at_limit, clk, rst_n, store_full, at_limit)
    // clear answers next cycle with an empty list
    `PIP_ASSERT_NEXT(a_clear_result, clk, rst_n, clear_beat, empty_result)
    // inside needs at least one edge
    `PIP_ASSERT_NOW(a_inside_edges, clk, rst_n, is_inside, has_edge)

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (.*);

// File: sim/tb_point_in_polygon_test_unit.sv
module tb_point_in_polygon_test_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_VERTICES = pip_pkg::MAX_VERTICES;
    localparam int         COORD_BITS   = pip_pkg::COORD_BITS;
    localparam int         TOTAL_BITS   = pip_pkg::TOTAL_BITS;
    localparam logic [1:0] MODE_CLEAR   = pip_pkg::MODE_CLEAR;
    localparam logic [1:0] MODE_APPEND  = pip_pkg::MODE_APPEND;
    localparam logic [1:0] MODE_QUERY   = pip_pkg::MODE_QUERY;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = MAX_VERTICES + 16;
    localparam int MAX_REPORTS  = 60;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic                  in_poly;
        logic                  closed;
        logic [TOTAL_BITS-1:0] total;
        logic                  full;
    } poly_status_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            mode;
    coord_t                coord_x;
    coord_t                coord_y;
    logic                  done;
    logic                  is_inside;
    logic                  is_closed;
    logic [TOTAL_BITS-1:0] vertex_total;
    logic                  store_full;

    // local copy of the vertex list
    coord_t poly_x [MAX_VERTICES];
    coord_t poly_y [MAX_VERTICES];
    int     poly_count;

    poly_status_t expected_status [$];

    int errors;
    int items_sent;
    int queries_sent;
    int inside_seen;
    int full_seen;
    int polygons_built;
    int burst_left;

    point_in_polygon_test_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .done         (done),
        .is_inside    (is_inside),
        .is_closed    (is_closed),
        .vertex_total (vertex_total),
        .store_full   (store_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int crossing_factor(input longint ax, ay, bx, by, cx, cy);
        longint tx;
        longint ty;
        longint d;
        if (ay == by && by == cy)
        begin
            if ((bx <= ax && ax <= cx) || (cx <= ax && ax <= bx))
                return 0;
            return 1;
        end
        if (by > cy)
        begin
            tx = bx;
            ty = by;
            bx = cx;
            by = cy;
            cx = tx;
            cy = ty;
        end
        if (ay == by && ax == bx)
            return 0;
        if (ay <= by || ay > cy)
            return 1;
        d = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        if (d > 0)
            return -1;
        if (d < 0)
            return 1;
        return 0;
    endfunction

    function automatic poly_status_t apply_polygon_item(input logic [1:0] m,
                                                        input coord_t x, y);
        poly_status_t s;
        int product;
        s = '0;
        case (m)
            MODE_CLEAR:
                poly_count = 0;
            MODE_APPEND:
            begin
                if (poly_count < MAX_VERTICES)
                begin
                    poly_x[poly_count] = x;
                    poly_y[poly_count] = y;
                    poly_count++;
                end
                else
                    s.full = 1'b1;
            end
            MODE_QUERY:
            begin
                product = -1;
                for (int i = 1; i < poly_count; i++)
                    product *= crossing_factor(x, y, poly_x[i-1], poly_y[i-1],
                                               poly_x[i], poly_y[i]);
                s.in_poly = (product >= 0);
            end
            default:
                ;
        endcase
        if (poly_count >= 2)
            s.closed = (poly_x[0] == poly_x[poly_count-1]) &&
                       (poly_y[0] == poly_y[poly_count-1]);
        s.total = poly_count[TOTAL_BITS-1:0];
        return s;
    endfunction

    function automatic coord_t rand_coord(input int span);
        if (span == 0)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // sender works in bursts separated by random gaps
    task automatic send_item(input logic [1:0] m, input coord_t x, y);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        start   <= 1'b1;
        mode    <= m;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_status.push_back(apply_polygon_item(m, x, y));
        items_sent++;
        if (m == MODE_QUERY)
            queries_sent++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        poly_status_t want;
        if (rst_n && done)
        begin
            if (expected_status.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected, expected none, got total %0d",
                             $realtime, vertex_total);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("is_inside", 8'(want.in_poly), 8'(is_inside));
                check_field("is_closed", 8'(want.closed), 8'(is_closed));
                check_field("vertex_total", 8'(want.total), 8'(vertex_total));
                check_field("store_full", 8'(want.full), 8'(store_full));
                if (want.in_poly)
                    inside_seen++;
                if (want.full)
                    full_seen++;
            end
        end
    end

    task automatic test_empty_and_unused();
        send_item(MODE_CLEAR, 0, 0);
        send_item(MODE_QUERY, 0, 0);
        send_item(MODE_UNUSED, 32767, -32768);
        send_item(MODE_APPEND, 5, 5);
        send_item(MODE_QUERY, 5, 5);
        send_item(MODE_UNUSED, -1, 0);
        send_item(MODE_APPEND, 5, 5);
        send_item(MODE_QUERY, 5, 5);
    endtask

    task automatic test_square();
        send_item(MODE_CLEAR, -1, -1);
        send_item(MODE_APPEND, 0, 0);
        send_item(MODE_APPEND, 10, 0);
        send_item(MODE_APPEND, 10, 10);
        send_item(MODE_APPEND, 0, 10);
        // open polygon, closing edge not tested
        send_item(MODE_QUERY, 5, 5);
        send_item(MODE_APPEND, 0, 0);
        send_item(MODE_QUERY, 5, 5);
        send_item(MODE_QUERY, 15, 5);
        send_item(MODE_QUERY, 10, 5);
        send_item(MODE_QUERY, 0, 0);
        send_item(MODE_QUERY, 5, 0);
        send_item(MODE_QUERY, -5, 0);
        send_item(MODE_QUERY, 5, 10);
        send_item(MODE_QUERY, 5, -1);
    endtask

    task automatic test_extremes();
        send_item(MODE_CLEAR, 32767, 32767);
        send_item(MODE_APPEND, -32768, -32768);
        send_item(MODE_APPEND, 32767, -32768);
        send_item(MODE_APPEND, 32767, 32767);
        send_item(MODE_APPEND, -32768, 32767);
        send_item(MODE_APPEND, -32768, -32768);
        send_item(MODE_QUERY, 0, 0);
        send_item(MODE_QUERY, 32767, 0);
        send_item(MODE_QUERY, -32768, 32767);
        send_item(MODE_QUERY, -1, -32767);
    endtask

    task automatic test_full_store();
        send_item(MODE_CLEAR, 0, 0);
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            if (i == 0 || i == MAX_VERTICES - 1)
                send_item(MODE_APPEND, -3, 4);
            else
                send_item(MODE_APPEND, rand_coord(50), rand_coord(50));
        end
        send_item(MODE_APPEND, 7, 7);
        send_item(MODE_APPEND, -32768, 32767);
        send_item(MODE_QUERY, 0, 0);
        send_item(MODE_QUERY, -3, 4);
        send_item(MODE_QUERY, rand_coord(50), rand_coord(50));
        send_item(MODE_UNUSED, 0, 0);
        send_item(MODE_CLEAR, 0, 0);
        send_item(MODE_QUERY, 0, 0);
    endtask

    // mostly clear, build, query sequences; the rest is noise
    task automatic test_random_polygons();
        int n_vert;
        int span;
        int pick;
        coord_t px [MAX_VERTICES + 8];
        coord_t py [MAX_VERTICES + 8];
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 5))
                    send_item(2'($urandom_range(0, 3)), coord_t'($urandom),
                              coord_t'($urandom));
            end
            else
            begin
                pick = $urandom_range(0, 9);
                span = (pick < 5) ? 8 : (pick < 8) ? 1000 : 0;
                if ($urandom_range(0, 19) == 0)
                    n_vert = $urandom_range(13, MAX_VERTICES + 4);
                else
                    n_vert = $urandom_range(1, 12);
                send_item(MODE_CLEAR, rand_coord(0), rand_coord(0));
                for (int i = 0; i < n_vert; i++)
                begin
                    px[i] = rand_coord(span);
                    py[i] = rand_coord(span);
                    if (i > 0 && i == n_vert - 1 && $urandom_range(0, 3) != 0)
                    begin
                        px[i] = px[0];
                        py[i] = py[0];
                    end
                    send_item(MODE_APPEND, px[i], py[i]);
                end
                polygons_built++;
                repeat ($urandom_range(2, 10))
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        send_item(MODE_QUERY, rand_coord(span), rand_coord(span));
                    else if (pick < 8)
                    begin
                        pick = $urandom_range(0, n_vert - 1);
                        send_item(MODE_QUERY, px[pick], py[pick]);
                    end
                    else
                        send_item(MODE_QUERY, rand_coord(0), rand_coord(0));
                end
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        mode           = MODE_CLEAR;
        coord_x        = '0;
        coord_y        = '0;
        poly_count     = 0;
        errors         = 0;
        items_sent     = 0;
        queries_sent   = 0;
        inside_seen    = 0;
        full_seen      = 0;
        polygons_built = 0;
        burst_left     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_unused();
        test_square();
        test_extremes();
        test_full_store();
        test_random_polygons();

        @(negedge clk);
        start <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d items, %0d queries over %0d random polygons", items_sent,
                 queries_sent, polygons_built);
        $display("answers inside or on boundary: %0d, appends dropped on full store: %0d",
                 inside_seen, full_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("%0t: run did not finish in time", $realtime);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_ctrl.sv
rtl/pip_datapath.sv
rtl/point_in_polygon_test_unit.sv
rtl/pip_checker.sv
sim/tb_point_in_polygon_test_unit.sv
